FILE: rtl/sha256_pkg.sv
// sha-256 digest package: shared types, sequencer states and hash constants
// no dependencies; imported by sha256_core and sha256_message_digest_top
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [7:0][31:0] hash_t;

  localparam int unsigned Rounds = 64;
  localparam int unsigned CountWidth = 61;

  typedef struct packed {
    logic start;
    logic init;
  } core_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_HASH,
    S_PAD1,
    S_PAD2,
    S_OUT
  } seq_state_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

FILE: rtl/sha256_message_digest_top.sv
// sha-256 message digest top: byte packing, padding sequencer and digest output
// depends on sha256_pkg and sha256_core
// a byte that neither fills a block nor ends the message keeps in_ready high; one that fills a block
// keeps in_ready low through load, 64 rounds in the shared round unit, fold and handoff
// a final transaction shows the first digest word after one compression or two; then one word per
// accepted cycle; rst clears the sequencer and byte count and reloads the hash
module sha256_message_digest_top
  import sha256_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);

  seq_state_t state, state_next;
  logic [CountWidth-1:0] byte_count, byte_count_next;
  logic final_pending, final_pending_next;
  logic last_block, last_block_next;
  logic need_pad2, need_pad2_next;
  logic [2:0] word_index_next;

  block_t block_words;
  block_t pad_block;
  hash_t hash;
  core_ctrl_t core_ctrl;
  core_stat_t core_stat;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic in_fire;
  logic out_fire;

  assign pos      = byte_count[5:0];
  assign bit_len  = {byte_count, 3'b000};
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_valid = (state == S_OUT);
  assign out_fire = out_valid && out_ready;
  assign digest_word = hash[word_index];
  assign last_word = (word_index == 3'd7);

  sha256_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (core_ctrl),
    .block (block_words),
    .hash  (hash),
    .stat  (core_stat)
  );

  // padded block: 0x80 at fill point, zeros after, bit length at tail if pos < 56; pad2: zeros, length
  always_comb begin
    pad_block = block_words;
    for (int b = 0; b < 64; b++) begin
      if (6'(b) == pos) begin
        pad_block[b >> 2][8 * (3 - (b & 3)) +: 8] = 8'h80;
      end else if (6'(b) > pos) begin
        pad_block[b >> 2][8 * (3 - (b & 3)) +: 8] = 8'h00;
      end
    end
    if (state == S_PAD2) begin
      pad_block = '0;
    end
    if (state == S_PAD2 || pos < 6'd56) begin
      pad_block[14] = bit_len[63:32];
      pad_block[15] = bit_len[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && has_byte) begin
      block_words[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= data_byte;
    end else if (state == S_PAD1 || state == S_PAD2) begin
      block_words <= pad_block;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      byte_count    <= '0;
      final_pending <= 1'b0;
      last_block    <= 1'b0;
      need_pad2     <= 1'b0;
      word_index    <= '0;
    end else begin
      state         <= state_next;
      byte_count    <= byte_count_next;
      final_pending <= final_pending_next;
      last_block    <= last_block_next;
      need_pad2     <= need_pad2_next;
      word_index    <= word_index_next;
    end
  end

  always_comb begin
    state_next         = state;
    byte_count_next    = byte_count;
    final_pending_next = final_pending;
    last_block_next    = last_block;
    need_pad2_next     = need_pad2;
    word_index_next    = word_index;
    core_ctrl          = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (has_byte) begin
            byte_count_next = byte_count + CountWidth'(1);
          end
          if (has_byte && pos == 6'd63) begin
            final_pending_next = end_of_message;
            state_next = S_LOAD;
          end else if (end_of_message) begin
            final_pending_next = 1'b1;
            state_next = S_PAD1;
          end
        end
      end
      S_LOAD: begin
        core_ctrl.start = 1'b1;
        state_next = S_HASH;
      end
      S_HASH: begin
        if (core_stat.done) begin
          if (last_block) begin
            word_index_next = '0;
            state_next = S_OUT;
          end else if (need_pad2) begin
            state_next = S_PAD2;
          end else if (final_pending) begin
            state_next = S_PAD1;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_PAD1: begin
        // no room for the length after the 0x80 byte: it goes in one more block
        if (pos < 6'd56) begin
          last_block_next = 1'b1;
        end else begin
          need_pad2_next = 1'b1;
        end
        state_next = S_LOAD;
      end
      S_PAD2: begin
        need_pad2_next  = 1'b0;
        last_block_next = 1'b1;
        state_next = S_LOAD;
      end
      S_OUT: begin
        if (out_fire) begin
          word_index_next = word_index + 3'd1;
          if (last_word) begin
            core_ctrl.init     = 1'b1;
            byte_count_next    = '0;
            final_pending_next = 1'b0;
            last_block_next    = 1'b0;
            need_pad2_next     = 1'b0;
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_start_idle_core: assert property (@(posedge clk) disable iff (rst)
    core_ctrl.start |-> !core_stat.busy)
    else $error("compression started while the core is busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_clear_after_digest: assert property (@(posedge clk) disable iff (rst)
    (out_fire && last_word) |=> (byte_count == '0) && in_ready)
    else $error("byte count not cleared after the last digest word");

  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (out_fire && !last_word) |=> out_valid && (word_index == 3'($past(word_index) + 3'd1)))
    else $error("digest words out of order");

  a_done_only_hashing: assert property (@(posedge clk) disable iff (rst)
    core_stat.done |-> (state == S_HASH))
    else $error("core finished outside the hash wait state");

endmodule

FILE: rtl/sha256_core.sv
// sha-256 compression unit: one round per cycle over 64 rounds, then a fold
// into the chaining value; depends on sha256_pkg
module sha256_core
  import sha256_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  core_ctrl_t ctrl,
  input  block_t     block,
  output hash_t      hash,
  output core_stat_t stat
);

  function automatic word_t rotr(word_t x, int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  hash_t  vars;
  block_t window;
  logic [5:0] round;
  logic busy;
  logic fold;
  logic done;

  word_t w_new;
  word_t sum1;
  word_t sum0;
  word_t choose;
  word_t major;
  word_t temp1;
  word_t temp2;

  // window holds w[t] .. w[t+15]; the next schedule word is w[t+16]
  always_comb begin
    w_new = window[0]
          + (rotr(window[1], 7) ^ rotr(window[1], 18) ^ (window[1] >> 3))
          + window[9]
          + (rotr(window[14], 17) ^ rotr(window[14], 19) ^ (window[14] >> 10));
    sum1   = rotr(vars[4], 6) ^ rotr(vars[4], 11) ^ rotr(vars[4], 25);
    choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    temp1  = vars[7] + sum1 + choose + ROUND_K[round] + window[0];
    sum0   = rotr(vars[0], 2) ^ rotr(vars[0], 13) ^ rotr(vars[0], 22);
    major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    temp2  = sum0 + major;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      fold  <= 1'b0;
      done  <= 1'b0;
      round <= '0;
      for (int i = 0; i < 8; i++) hash[i] <= INIT_HASH[i];
    end else begin
      done <= fold;
      if (ctrl.init) begin
        for (int i = 0; i < 8; i++) hash[i] <= INIT_HASH[i];
      end
      if (ctrl.start) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (busy) begin
        round <= round + 6'd1;
        if (round == 6'(Rounds - 1)) begin
          busy <= 1'b0;
          fold <= 1'b1;
        end
      end
      if (fold) begin
        for (int i = 0; i < 8; i++) hash[i] <= hash[i] + vars[i];
        fold <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      window <= block;
      vars   <= hash;
    end else if (busy) begin
      for (int i = 0; i < 15; i++) window[i] <= window[i + 1];
      window[15] <= w_new;
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + temp1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= temp1 + temp2;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule
